// File: rtl/core/bdlp_pkg.sv
// Package for the button debouncer: constants, register codes and shared types.
package bdlp_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd700;
  localparam logic        LONG_ENABLE_RST   = 1'b1;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MS   = 2'd0,
    CFG_LONG_PRESS_MS = 2'd1,
    CFG_LONG_ENABLE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic        long_press_enable;
  } cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic is_pressed;
  } result_t;

endpackage

// File: rtl/core/bdlp_in_if.sv
// Input item channel: op, millisecond tick and raw pin level.
interface bdlp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [bdlp_pkg::NOW_W-1:0] now_ms;
  logic                      pin_high;

  modport source (output valid, op, now_ms, pin_high, input ready);
  modport sink   (input valid, op, now_ms, pin_high, output ready);
endinterface

// File: rtl/core/bdlp_out_if.sv
// Result channel: press pulses and debounced state.
interface bdlp_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic is_pressed;

  modport source (output valid, short_press, long_press, is_pressed, input ready);
  modport sink   (input valid, short_press, long_press, is_pressed, output ready);
endinterface

// File: rtl/core/bdlp_cfg_if.sv
// Configuration write channel: register index and write data.
interface bdlp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bdlp_pkg::CFG_IDX_W-1:0]  index;
  logic [bdlp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/button_debounce_long_press.sv
// Top level of the button debouncer with long-press detection.
// Pipeline: a word is registered in the input stage, then its result in the result stage.
// Throughput: one word per cycle while result.ready does not stall; debounce state is
// updated in the result stage by one subtract-and-compare, and the next word reads it.
// Reset (rst, synchronous): registers back to 50 / 700 / enabled, button
// released, nothing pending, tick zero, both pipeline stages empty.
module button_debounce_long_press #(
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  bdlp_in_if.sink   item,
  bdlp_out_if.source result,
  bdlp_cfg_if.sink  cfg
);

  bdlp_pkg::cfg_t cfg_regs;

  logic                       s1_valid;
  logic                       s1_op;
  logic [bdlp_pkg::NOW_W-1:0] s1_now_ms;
  logic                       s1_pin_high;

  logic                 out_valid;
  bdlp_pkg::result_t    out_data;

  logic [TIME_BITS-1:0] last_event_time;
  logic                 stable_pressed;
  logic                 press_open;
  logic [TIME_BITS-1:0] last_event_time_next;
  logic                 stable_pressed_next;
  logic                 press_open_next;
  bdlp_pkg::result_t    step_result;

  logic advance;
  logic fire;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ms       <= bdlp_pkg::DEBOUNCE_MS_RST;
      cfg_regs.long_press_ms     <= bdlp_pkg::LONG_PRESS_MS_RST;
      cfg_regs.long_press_enable <= bdlp_pkg::LONG_ENABLE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bdlp_pkg::CFG_DEBOUNCE_MS:   cfg_regs.debounce_ms       <= cfg.data;
        bdlp_pkg::CFG_LONG_PRESS_MS: cfg_regs.long_press_ms     <= cfg.data;
        bdlp_pkg::CFG_LONG_ENABLE:   cfg_regs.long_press_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid || result.ready;
  assign fire       = s1_valid && advance;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_op       <= item.op;
      s1_now_ms   <= item.now_ms;
      s1_pin_high <= item.pin_high;
    end
  end

  bdlp_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cfg                  (cfg_regs),
    .op                   (s1_op),
    .now_ms               (s1_now_ms),
    .pin_high             (s1_pin_high),
    .last_event_time      (last_event_time),
    .stable_pressed       (stable_pressed),
    .press_open           (press_open),
    .last_event_time_next (last_event_time_next),
    .stable_pressed_next  (stable_pressed_next),
    .press_open_next      (press_open_next),
    .result               (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_event_time <= '0;
      stable_pressed  <= 1'b0;
      press_open      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (fire) begin
        last_event_time <= last_event_time_next;
        stable_pressed  <= stable_pressed_next;
        press_open      <= press_open_next;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= step_result;
    end
  end

  assign result.valid       = out_valid;
  assign result.short_press = out_data.short_press;
  assign result.long_press  = out_data.long_press;
  assign result.is_pressed  = out_data.is_pressed;

  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.short_press && out_data.long_press))
    else $error("short and long press pulses on one word");

  a_pending_pressed: assert property (@(posedge clk) disable iff (rst)
    press_open |-> stable_pressed)
    else $error("press pending while released");

  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(last_event_time))
    else $error("event time changed without a word in the result stage");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.is_pressed) |-> !press_open)
    else $error("pending press survives a release");

endmodule

// File: rtl/core/bdlp_step.sv
// Per-word decision logic: time gate, state guard and press classification.
module bdlp_step #(
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input  bdlp_pkg::cfg_t          cfg,
  input  logic                    op,
  input  logic [bdlp_pkg::NOW_W-1:0] now_ms,
  input  logic                    pin_high,
  input  logic [TIME_BITS-1:0]    last_event_time,
  input  logic                    stable_pressed,
  input  logic                    press_open,
  output logic [TIME_BITS-1:0]    last_event_time_next,
  output logic                    stable_pressed_next,
  output logic                    press_open_next,
  output bdlp_pkg::result_t       result
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 debounce_ok;
  logic                 long_ok;
  logic                 pending_mid;

  assign now_t       = TIME_BITS'(now_ms);
  assign elapsed     = now_t - last_event_time;
  assign debounce_ok = elapsed >= TIME_BITS'(cfg.debounce_ms);
  assign long_ok     = elapsed >= TIME_BITS'(cfg.long_press_ms);

  always_comb begin
    last_event_time_next = last_event_time;
    stable_pressed_next  = stable_pressed;
    press_open_next      = press_open;
    result.short_press   = 1'b0;
    result.long_press    = 1'b0;
    pending_mid          = press_open;
    if (op == bdlp_pkg::OP_EDGE) begin
      if (debounce_ok && !stable_pressed) begin
        last_event_time_next = now_t;
        stable_pressed_next  = 1'b1;
        if (cfg.long_press_enable) begin
          press_open_next = 1'b1;
        end else begin
          result.short_press = 1'b1;
        end
      end
    end else if (stable_pressed) begin
      // promotion is checked before release
      if (press_open && long_ok) begin
        pending_mid       = 1'b0;
        result.long_press = 1'b1;
      end
      press_open_next = pending_mid;
      if (pin_high && debounce_ok) begin
        stable_pressed_next  = 1'b0;
        press_open_next      = 1'b0;
        result.short_press   = pending_mid;
        last_event_time_next = now_t;
      end
    end
    result.is_pressed = stable_pressed_next;
  end

endmodule

// File: tb/sv/button_debounce_long_press_tb.sv
`timescale 1ns / 1ps
// Testbench for the button debouncer: directed and random press sequences checked per word.
module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int STALL_PCT  = 28;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;

  bdlp_in_if  item_if();
  bdlp_out_if result_if();
  bdlp_cfg_if cfg_if();

  button_debounce_long_press uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  cfg_t        cfg_shadow;
  logic [31:0] last_tick;
  logic        held;
  logic        pending;
  result_t     press_reports[$];
  logic [31:0] tick_ms;
  int          words_sent;
  int          errors = 0;
  int          idle_cycles = 0;
  bit          no_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) result_if.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);

  // debounced button state for one word; updates the shadow state
  function automatic result_t predict_press(logic op, logic [31:0] now, logic pin);
    result_t     r;
    logic [31:0] elapsed;
    r = '0;
    elapsed = now - last_tick;
    if (op == OP_EDGE) begin
      if (elapsed >= {16'd0, cfg_shadow.debounce_ms} && !held) begin
        last_tick = now;
        held = 1'b1;
        if (cfg_shadow.long_press_enable) pending = 1'b1;
        else r.short_press = 1'b1;
      end
    end else if (held) begin
      if (pending && elapsed >= {16'd0, cfg_shadow.long_press_ms}) begin
        pending = 1'b0;
        r.long_press = 1'b1;
      end
      if (pin && elapsed >= {16'd0, cfg_shadow.debounce_ms}) begin
        held = 1'b0;
        if (pending) begin
          pending = 1'b0;
          r.short_press = 1'b1;
        end
        last_tick = now;
      end
    end
    r.is_pressed = held;
    return r;
  endfunction

  task automatic check_bit(string field, logic want, logic got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch: expected %0b, actual %0b", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (press_reports.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word: expected none, actual short=%0b long=%0b pressed=%0b",
                 $time, result_if.short_press, result_if.long_press, result_if.is_pressed);
      end else begin
        want = press_reports.pop_front();
        check_bit("short_press", want.short_press, result_if.short_press);
        check_bit("long_press", want.long_press, result_if.long_press);
        check_bit("is_pressed", want.is_pressed, result_if.is_pressed);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic send_word(logic op, logic [31:0] now, logic pin);
    if (!no_stall) begin
      while ($urandom_range(99) < STALL_PCT) begin
        item_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    item_if.valid    <= 1'b1;
    item_if.op       <= op;
    item_if.now_ms   <= now;
    item_if.pin_high <= pin;
    do @(posedge clk); while (!item_if.ready);
    press_reports.push_back(predict_press(op, now, pin));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (press_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_DEBOUNCE_MS:   cfg_shadow.debounce_ms = data;
      CFG_LONG_PRESS_MS: cfg_shadow.long_press_ms = data;
      CFG_LONG_ENABLE:   cfg_shadow.long_press_enable = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] db, logic [15:0] lp, logic en);
    logic [15:0] junk;
    junk = 16'($urandom);
    drain();
    write_reg(CFG_DEBOUNCE_MS, db);
    write_reg(CFG_LONG_PRESS_MS, lp);
    write_reg(CFG_LONG_ENABLE, {junk[15:1], en});
    cfg_if.valid <= 1'b0;
  endtask

  // tick advance aimed at the debounce and long-press boundaries
  function automatic logic [31:0] pick_step();
    logic [31:0] db, lp, span;
    db = cfg_shadow.debounce_ms;
    lp = cfg_shadow.long_press_ms;
    span = (db > lp ? db : lp) * 2 + 2;
    case ($urandom_range(8))
      0: return 0;
      1: return $urandom_range(20);
      2: return (db == 0) ? 0 : db - 1;
      3: return db;
      4: return db + 1;
      5: return (lp == 0) ? 0 : lp - 1;
      6: return lp;
      7: return lp + 1;
      default: return $urandom_range(span);
    endcase
  endfunction

  // bouncing edges, a hold with pin glitches, then a bouncing release
  task automatic press_sequence();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      tick_ms = tick_ms + pick_step();
      send_word(OP_EDGE, tick_ms, 1'($urandom_range(1)));
    end
    n = $urandom_range(0, 5);
    repeat (n) begin
      tick_ms = tick_ms + pick_step();
      send_word(($urandom_range(9) == 0) ? OP_EDGE : OP_POLL, tick_ms,
                $urandom_range(4) == 0);
    end
    n = $urandom_range(1, 4);
    repeat (n) begin
      tick_ms = tick_ms + pick_step();
      send_word(OP_POLL, tick_ms, $urandom_range(3) != 0);
    end
  endtask

  task automatic run_phase(int count);
    int first;
    first = words_sent;
    while (words_sent - first < count) begin
      if ($urandom_range(7) != 0) begin
        press_sequence();
      end else begin
        case ($urandom_range(2))
          0: tick_ms = $urandom;
          1: tick_ms = 32'hFFFF_FFFF - $urandom_range(2000);
          default: tick_ms = tick_ms + pick_step();
        endcase
        send_word(1'($urandom_range(1)), tick_ms, 1'($urandom_range(1)));
      end
    end
  endtask

  // reset register values: short press, long press, bounce rejection
  task automatic test_short_and_long();
    send_word(OP_POLL, 32'd0, 1'b1);
    send_word(OP_EDGE, 32'd10, 1'b1);
    send_word(OP_EDGE, 32'd50, 1'b0);
    send_word(OP_EDGE, 32'd200, 1'b0);
    send_word(OP_POLL, 32'd80, 1'b1);
    send_word(OP_POLL, 32'd749, 1'b0);
    send_word(OP_POLL, 32'd750, 1'b0);
    send_word(OP_POLL, 32'd800, 1'b1);
    send_word(OP_EDGE, 32'd849, 1'b0);
    send_word(OP_EDGE, 32'd850, 1'b1);
    send_word(OP_POLL, 32'd900, 1'b1);
  endtask

  // long threshold and release reached by the same poll
  task automatic test_promote_on_release();
    send_word(OP_EDGE, 32'd2000, 1'b0);
    send_word(OP_POLL, 32'd2700, 1'b1);
  endtask

  // press pending when long-press mode is switched off, then edge mode
  task automatic test_mode_switch_pending();
    send_word(OP_EDGE, 32'd3000, 1'b0);
    set_config(16'd50, 16'd700, 1'b0);
    send_word(OP_POLL, 32'd3100, 1'b1);
    send_word(OP_EDGE, 32'd3200, 1'b0);
    send_word(OP_POLL, 32'd3250, 1'b1);
  endtask

  // maximum thresholds across the tick wrap
  task automatic test_tick_wrap();
    set_config(16'hFFFF, 16'hFFFF, 1'b1);
    send_word(OP_EDGE, 32'hFFFF_FF00, 1'b1);
    send_word(OP_POLL, 32'h0000_FEFF, 1'b0);
    send_word(OP_POLL, 32'h0000_FEFE, 1'b1);
    send_word(OP_POLL, 32'h0000_FEFF, 1'b1);
  endtask

  task automatic test_zero_thresholds();
    set_config(16'd0, 16'd0, 1'b1);
    send_word(OP_EDGE, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_POLL, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_POLL, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_EDGE, 32'd0, 1'b1);
  endtask

  task automatic test_random();
    tick_ms = 32'd0;
    set_config(16'd50, 16'd700, 1'b1);
    run_phase(300);
    set_config(16'($urandom_range(200)), 16'($urandom_range(2000)), 1'b0);
    run_phase(300);
    no_stall = 1'b1;
    set_config(16'd0, 16'd0, 1'b1);
    run_phase(300);
    no_stall = 1'b0;
    set_config(16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(300);
    set_config(16'($urandom), 16'($urandom), 1'b1);
    run_phase(300);
    set_config(16'($urandom_range(100)), 16'($urandom_range(300)), 1'($urandom_range(1)));
    run_phase(300);
  endtask

  initial begin
    rst              = 1'b1;
    item_if.valid    = 1'b0;
    item_if.op       = OP_POLL;
    item_if.now_ms   = '0;
    item_if.pin_high = 1'b1;
    result_if.ready  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_DEBOUNCE_MS;
    cfg_if.data      = '0;
    no_stall         = 1'b0;
    words_sent       = 0;
    tick_ms          = '0;
    cfg_shadow       = {DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, LONG_ENABLE_RST};
    last_tick        = '0;
    held             = 1'b0;
    pending          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_and_long();
    test_promote_on_release();
    test_mode_switch_pending();
    test_tick_wrap();
    test_zero_thresholds();
    test_random();

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
